// File: hw/rtl/lfid_pkg.sv
package lfid_pkg;

  // Fixed field widths of the ports
  localparam int CMD_W        = 2;
  localparam int ID_FIELD_W   = 5;
  localparam int LIMIT_W      = 5;
  localparam int COUNT_FIELD_W = 5;

  // Default capacity and register reset value
  localparam int MAX_SLOTS_DEF  = 16;
  localparam int SLOT_LIMIT_RST = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN   = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  // Broadcast controls shared by every cell of the age chain
  typedef struct packed {
    logic clear;     // drop every entry
    logic match_en;  // destroy: cells compare their id against the target
  } cell_cmd_t;

endpackage

// File: hw/rtl/lfid_cell.sv
module lfid_cell import lfid_pkg::*; #(
  parameter int ID_W = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  cell_cmd_t       cmd,
  input  logic [ID_W-1:0] tgt_id,
  input  logic            load,
  input  logic [ID_W-1:0] load_id,
  input  logic            rm_in,
  output logic            rm_out,
  input  logic            nb_valid,
  input  logic [ID_W-1:0] nb_id,
  output logic            valid,
  output logic [ID_W-1:0] id
);

  logic match;

  // Once a removal point is passed, every younger cell takes its neighbor's entry
  assign match  = cmd.match_en && valid && (id == tgt_id);
  assign rm_out = rm_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rm_out) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id <= load_id;
    end else if (rm_out) begin
      id <= nb_id;
    end
  end

endmodule

// File: hw/rtl/lfid_free_enc.sv
module lfid_free_enc import lfid_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int ID_W      = $clog2(MAX_SLOTS + 2)
) (
  input  logic [MAX_SLOTS:0] in_use,   // bit k stands for identifier k+1
  output logic [ID_W-1:0]    free_id
);

  // Lowest identifier whose flag is clear; the top one is always free when
  // all lower ones are taken
  always_comb begin
    free_id = ID_W'(MAX_SLOTS + 1);
    for (int i = MAX_SLOTS; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_id = ID_W'(i + 1);
      end
    end
  end

endmodule

// File: hw/rtl/lowest_free_id_fifo_slots_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | command, create_ok, target_id
// out      | out_valid / out_ready| new_id, evicted_id, active_count
// cfg      | cfg_we (no wait)     | cfg_wdata -> slot_limit
//
// Each transfer is accepted in IDLE; WORK then runs the lowest-free encoder
// and moves the age chain once.
// The next item is accepted while a result still waits in the output register;
// WORK holds until that register is free.
// Lowering slot_limit trims one oldest entry per cycle while in IDLE; in_ready
// stays low until the trim is done.
// Reset (rst, synchronous) empties the set and loads slot_limit with 16.
module lowest_free_id_fifo_slots_top import lfid_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic                     create_ok,
  input  logic [ID_FIELD_W-1:0]    target_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ID_FIELD_W-1:0]    new_id,
  output logic [ID_FIELD_W-1:0]    evicted_id,
  output logic [COUNT_FIELD_W-1:0] active_count,
  input  logic                     cfg_we,
  input  logic [LIMIT_W-1:0]       cfg_wdata
);

  localparam int ID_W = $clog2(MAX_SLOTS + 2);
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam logic [CW-1:0] RST_EFF =
      (SLOT_LIMIT_RST > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(SLOT_LIMIT_RST);

  state_t state, state_next;

  cmd_t                  cmd_r;
  logic                  create_ok_r;
  logic [ID_FIELD_W-1:0] target_r;

  logic [MAX_SLOTS+1:0] id_map, id_map_next;   // bit k set: identifier k is live
  logic [CW-1:0]        count, count_next;
  logic [LIMIT_W-1:0]   slot_limit;
  logic [CW-1:0]        trim_cap;               // trim down to this count
  logic [CW-1:0]        eff_limit, eff_new;

  logic [ID_W-1:0] free_id;
  logic [ID_W-1:0] tgt_id;
  logic            tgt_live;
  logic            trimming;
  logic            fire;

  cell_cmd_t          cell_cmd;
  logic               rm_head;
  logic               spawn_load;
  logic [CW-1:0]      tail;
  logic [ID_W-1:0]    res_new, res_evict;

  logic               cell_valid [MAX_SLOTS];
  logic [ID_W-1:0]    cell_id    [MAX_SLOTS];
  logic [MAX_SLOTS:0] rm_chain;

  // Limits above the capacity act as the capacity
  assign eff_limit = (32'(slot_limit) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slot_limit);
  assign eff_new   = (32'(cfg_wdata) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg_wdata);

  assign trimming = (state == ST_IDLE) && (count > trim_cap);
  assign in_ready = (state == ST_IDLE) && !(count > trim_cap);
  assign fire     = (state == ST_WORK) && (!out_valid || out_ready);

  // Destroy only looks at identifiers that can exist
  assign tgt_id   = ID_W'(target_r);
  assign tgt_live = (target_r != '0) && (32'(target_r) <= 32'(MAX_SLOTS + 1)) && id_map[tgt_id];

  lfid_free_enc #(
    .MAX_SLOTS(MAX_SLOTS),
    .ID_W     (ID_W)
  ) u_free_enc (
    .in_use (id_map[MAX_SLOTS+1:1]),
    .free_id(free_id)
  );

  // Age chain: cell 0 is the oldest entry
  assign rm_chain[0] = rm_head;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic            nb_valid;
    logic [ID_W-1:0] nb_id;

    if (i == MAX_SLOTS - 1) begin : g_last
      assign nb_valid = 1'b0;
      assign nb_id    = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_id    = cell_id[i+1];
    end

    lfid_cell #(
      .ID_W(ID_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cell_cmd),
      .tgt_id  (tgt_id),
      .load    (spawn_load && (tail == CW'(i))),
      .load_id (free_id),
      .rm_in   (rm_chain[i]),
      .rm_out  (rm_chain[i+1]),
      .nb_valid(nb_valid),
      .nb_id   (nb_id),
      .valid   (cell_valid[i]),
      .id      (cell_id[i])
    );
  end

  always_comb begin
    state_next     = state;
    id_map_next    = id_map;
    count_next     = count;
    cell_cmd       = '0;
    rm_head        = 1'b0;
    spawn_load     = 1'b0;
    tail           = count;
    res_new        = '0;
    res_evict      = '0;

    unique case (state)
      ST_IDLE: begin
        if (trimming) begin
          // Drop the oldest entry, unreported
          rm_head                 = 1'b1;
          id_map_next[cell_id[0]] = 1'b0;
          count_next              = count - CW'(1);
        end else if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (fire) begin
          state_next = ST_IDLE;
          case (cmd_r)
            CMD_SPAWN: begin
              if ((eff_limit != '0) && create_ok_r) begin
                if (count >= eff_limit) begin
                  // Evict the oldest, append at the freed tail
                  rm_head                 = 1'b1;
                  id_map_next[cell_id[0]] = 1'b0;
                  res_evict               = cell_id[0];
                  tail                    = count - CW'(1);
                end else begin
                  count_next = count + CW'(1);
                end
                spawn_load           = 1'b1;
                id_map_next[free_id] = 1'b1;
                res_new              = free_id;
              end
            end
            CMD_DESTROY: begin
              if (tgt_live) begin
                cell_cmd.match_en   = 1'b1;
                id_map_next[tgt_id] = 1'b0;
                count_next          = count - CW'(1);
                res_evict           = tgt_id;
              end
            end
            CMD_CLEAR: begin
              cell_cmd.clear = 1'b1;
              id_map_next    = '0;
              count_next     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_map     <= '0;
      count      <= '0;
      slot_limit <= LIMIT_W'(SLOT_LIMIT_RST);
      trim_cap   <= RST_EFF;
      out_valid  <= 1'b0;
    end else begin
      id_map <= id_map_next;
      count  <= count_next;
      if (cfg_we) begin
        slot_limit <= cfg_wdata;
        // A pending trim keeps the tightest limit written since it began
        if ((count > trim_cap) && (trim_cap < eff_new)) begin
          trim_cap <= trim_cap;
        end else begin
          trim_cap <= eff_new;
        end
      end else if (count <= trim_cap) begin
        trim_cap <= eff_limit;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted item for the WORK cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r       <= cmd_t'(command);
      create_ok_r <= create_ok;
      target_r    <= target_id;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      new_id       <= ID_FIELD_W'(res_new);
      evicted_id   <= ID_FIELD_W'(res_evict);
      active_count <= COUNT_FIELD_W'(count_next);
    end
  end

endmodule

// File: hw/rtl/lfid_checker.sv
module lfid_checker import lfid_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ID_FIELD_W-1:0]    new_id,
  input logic [ID_FIELD_W-1:0]    evicted_id,
  input logic [COUNT_FIELD_W-1:0] active_count
);

  // An accepted item never shows its result in the very next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after transfer");

  // The count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (32'(active_count) <= 32'(MAX_SLOTS)))
    else $error("active_count above capacity");

  // A fresh identifier is never the one evicted in the same step, and the count is then nonzero
  a_new_not_evicted: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (new_id != '0) && (MAX_SLOTS < 31)) |->
        ((new_id != evicted_id) && (active_count != '0)))
    else $error("spawn result inconsistent");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=>
        (out_valid && $stable(new_id) && $stable(evicted_id) && $stable(active_count)))
    else $error("stalled result changed");

endmodule

bind lowest_free_id_fifo_slots_top lfid_checker #(
  .MAX_SLOTS(MAX_SLOTS)
) u_lfid_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .new_id      (new_id),
  .evicted_id  (evicted_id),
  .active_count(active_count)
);
